// ----- hw/rtl/tto_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tto_pkg
// Shared types and codes of the task timeout table.
// ----------------------------------------------------------------------------
package tto_pkg;

  localparam int unsigned IndexW = 4;
  localparam int unsigned MaskW  = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned PrioW  = 8;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_RESUME = 2'd2,
    OP_QUERY  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_NOT_INSTALLED = 2'd1,
    ST_NOT_WAITING   = 2'd2
  } status_e;

  typedef struct packed {
    opcode_e             opcode;
    logic [IndexW-1:0]   entry_index;
    logic [TimeW-1:0]    elapsed_ticks;
    logic [TimeW-1:0]    new_timeout;
    logic                new_installed;
    logic                new_waiting;
    logic [PrioW-1:0]    new_priority;
    logic [PrioW-1:0]    running_priority;
    logic                running_idle;
  } tto_req_t;

  typedef struct packed {
    status_e             status;
    logic                preempt;
    logic [MaskW-1:0]    woken_mask;
    logic [TimeW-1:0]    next_wake;
    logic                pending_finite;
  } tto_rsp_t;

  // per-entry outcome of the head update
  typedef struct packed {
    logic    woke;
    logic    preempt;
    status_e status;
  } upd_flags_t;

endpackage
`default_nettype wire

// ----- hw/rtl/tto_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tto_cell
// One slot of the entry ring; takes its neighbour's entry on every shift.
// ----------------------------------------------------------------------------
module tto_cell #(
  parameter int unsigned PRIO_BITS    = 8,
  parameter int unsigned TIMEOUT_BITS = 32
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     shift_i,
  input  wire                     inst_i,
  input  wire                     wait_i,
  input  wire  [TIMEOUT_BITS-1:0] rt_i,
  input  wire  [PRIO_BITS-1:0]    prio_i,
  input  wire                     mark_i,
  output logic                    inst_o,
  output logic                    wait_o,
  output logic [TIMEOUT_BITS-1:0] rt_o,
  output logic [PRIO_BITS-1:0]    prio_o,
  output logic                    mark_o
);

  logic                    inst_q;
  logic                    wait_q;
  logic [TIMEOUT_BITS-1:0] rt_q;
  logic [PRIO_BITS-1:0]    prio_q;
  logic                    mark_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inst_q <= 1'b0;
      wait_q <= 1'b0;
      rt_q   <= '0;
      prio_q <= '0;
      mark_q <= 1'b0;
    end else if (shift_i) begin
      inst_q <= inst_i;
      wait_q <= wait_i;
      rt_q   <= rt_i;
      prio_q <= prio_i;
      mark_q <= mark_i;
    end
  end

  assign inst_o = inst_q;
  assign wait_o = wait_q;
  assign rt_o   = rt_q;
  assign prio_o = prio_q;
  assign mark_o = mark_q;

endmodule
`default_nettype wire

// ----- hw/rtl/tto_update.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tto_update
// Applies the current command to the entry leaving the head of the ring.
// ----------------------------------------------------------------------------
module tto_update #(
  parameter int unsigned PRIO_BITS    = 8,
  parameter int unsigned TIMEOUT_BITS = 32
) (
  input  tto_pkg::tto_req_t       req_i,
  input  wire                     hit_i,
  input  wire                     inst_i,
  input  wire                     wait_i,
  input  wire  [TIMEOUT_BITS-1:0] rt_i,
  input  wire  [PRIO_BITS-1:0]    prio_i,
  input  wire                     mark_i,
  output logic                    inst_o,
  output logic                    wait_o,
  output logic [TIMEOUT_BITS-1:0] rt_o,
  output logic [PRIO_BITS-1:0]    prio_o,
  output logic                    mark_o,
  output tto_pkg::upd_flags_t     flags_o
);
  import tto_pkg::*;

  localparam logic [TIMEOUT_BITS-1:0] ToInf = {TIMEOUT_BITS{1'b1}};

  logic [TIMEOUT_BITS-1:0] elapsed;
  logic [TIMEOUT_BITS-1:0] diff;
  logic [TIMEOUT_BITS-1:0] sub;
  logic                    borrow;
  logic                    finite;
  logic [PRIO_BITS-1:0]    run_prio;

  assign elapsed  = req_i.elapsed_ticks[TIMEOUT_BITS-1:0];
  assign run_prio = req_i.running_priority[PRIO_BITS-1:0];
  assign finite   = (rt_i != ToInf);
  assign {borrow, diff} = {1'b0, rt_i} - {1'b0, elapsed};
  assign sub      = borrow ? '0 : diff;

  always_comb begin
    inst_o          = inst_i;
    wait_o          = wait_i;
    rt_o            = rt_i;
    prio_o          = prio_i;
    mark_o          = mark_i;
    flags_o.woke    = 1'b0;
    flags_o.status  = ST_OK;
    unique case (req_i.opcode)
      OP_TICK: begin
        // woken entries land on zero, so the second pass leaves them alone
        if (finite && (wait_i || inst_i)) begin
          rt_o = sub;
        end
        if (finite && wait_i && (sub == '0)) begin
          wait_o       = 1'b0;
          mark_o       = 1'b1;
          flags_o.woke = 1'b1;
        end
      end
      OP_WRITE: begin
        if (hit_i) begin
          inst_o = req_i.new_installed;
          wait_o = req_i.new_waiting;
          rt_o   = req_i.new_timeout[TIMEOUT_BITS-1:0];
          prio_o = req_i.new_priority[PRIO_BITS-1:0];
          mark_o = 1'b0;
        end
      end
      OP_RESUME: begin
        if (hit_i) begin
          if (!inst_i) begin
            flags_o.status = ST_NOT_INSTALLED;
          end else if (!wait_i) begin
            flags_o.status = ST_NOT_WAITING;
          end else begin
            wait_o       = 1'b0;
            mark_o       = 1'b1;
            flags_o.woke = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    flags_o.preempt = flags_o.woke && ((prio_i < run_prio) || req_i.running_idle);
  end

endmodule
`default_nettype wire

// ----- hw/rtl/task_timeout_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// task_timeout_table
// Task timeout table: ticks, entry writes, forced resumes and queries.
// ----------------------------------------------------------------------------
// Usage:
//   A command in req_i is taken on a clock edge with start high and busy low.
//   The entries sit in a ring of NUM_ENTRIES cells that rotates by one cell a
//   cycle while a command runs; the command is applied to the entry leaving
//   the head cell, and the summary (next wake, pending timeout) is gathered
//   from the tail cell in the next cycle. One full turn of the ring restores
//   every entry to its cell. busy is high from the transfer through the turn
//   of the ring and the summary state; done_o then pulses for one cycle with
//   the result on rsp_o, in the same cycle busy falls, so a new command may
//   be started then. The block takes no new command while it is busy, so a
//   command is finished, with its result, before the next one is taken.
//   The receiver cannot stall: the result is valid only while done_o is high.
//   Reset clears every entry (not installed, not waiting, zero timeout and
//   priority) and returns the block to idle with no result pending.
// ----------------------------------------------------------------------------
module task_timeout_table #(
  parameter int unsigned NUM_ENTRIES  = 16,
  parameter int unsigned PRIO_BITS    = 8,
  parameter int unsigned TIMEOUT_BITS = 32
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start,
  output logic               busy,
  input  tto_pkg::tto_req_t  req_i,
  output logic               done_o,
  output tto_pkg::tto_rsp_t  rsp_o
);
  import tto_pkg::*;

  localparam int unsigned IdxW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int unsigned CmpW = (IdxW > IndexW) ? IdxW : IndexW;
  localparam logic [TIMEOUT_BITS-1:0] ToInf = {TIMEOUT_BITS{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_SUM  = 3'b100
  } state_e;

  state_e                  state_q, state_d;
  tto_req_t                req_q;
  logic [IdxW-1:0]         step_q, step_d;
  logic                    preempt_q, preempt_d;
  logic [MaskW-1:0]        woken_q, woken_d;
  status_e                 status_q, status_d;
  logic [TIMEOUT_BITS-1:0] next_q, next_d;
  logic                    pend_q, pend_d;
  tto_rsp_t                rsp_q, rsp_d;
  logic                    done_q, done_d;

  // ring
  logic [NUM_ENTRIES-1:0]  c_inst;
  logic [NUM_ENTRIES-1:0]  c_wait;
  logic [NUM_ENTRIES-1:0]  c_mark;
  logic [TIMEOUT_BITS-1:0] c_rt   [NUM_ENTRIES];
  logic [PRIO_BITS-1:0]    c_prio [NUM_ENTRIES];

  logic                    u_inst, u_wait, u_mark;
  logic [TIMEOUT_BITS-1:0] u_rt;
  logic [PRIO_BITS-1:0]    u_prio;
  upd_flags_t              flags;
  logic                    hit;
  logic                    shift;
  logic                    last_step;
  logic [TIMEOUT_BITS-1:0] sum_next;
  logic                    sum_pend;
  logic [TIMEOUT_BITS-1:0] tail_rt;
  logic                    tail_wait;
  logic                    tail_inst;
  logic                    start_ok;
  status_e                 status_init;

  assign shift     = (state_q == S_RUN);
  assign hit       = (CmpW'(req_q.entry_index) == CmpW'(step_q));
  assign last_step = (step_q == IdxW'(NUM_ENTRIES - 1));
  assign start_ok  = start && (state_q == S_IDLE);

  for (genvar k = 0; k < NUM_ENTRIES; k++) begin : g_cell
    if (k == NUM_ENTRIES - 1) begin : g_tail
      tto_cell #(
        .PRIO_BITS    (PRIO_BITS),
        .TIMEOUT_BITS (TIMEOUT_BITS)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .inst_i  (u_inst),
        .wait_i  (u_wait),
        .rt_i    (u_rt),
        .prio_i  (u_prio),
        .mark_i  (u_mark),
        .inst_o  (c_inst[k]),
        .wait_o  (c_wait[k]),
        .rt_o    (c_rt[k]),
        .prio_o  (c_prio[k]),
        .mark_o  (c_mark[k])
      );
    end else begin : g_body
      tto_cell #(
        .PRIO_BITS    (PRIO_BITS),
        .TIMEOUT_BITS (TIMEOUT_BITS)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .inst_i  (c_inst[k+1]),
        .wait_i  (c_wait[k+1]),
        .rt_i    (c_rt[k+1]),
        .prio_i  (c_prio[k+1]),
        .mark_i  (c_mark[k+1]),
        .inst_o  (c_inst[k]),
        .wait_o  (c_wait[k]),
        .rt_o    (c_rt[k]),
        .prio_o  (c_prio[k]),
        .mark_o  (c_mark[k])
      );
    end
  end

  tto_update #(
    .PRIO_BITS    (PRIO_BITS),
    .TIMEOUT_BITS (TIMEOUT_BITS)
  ) u_update (
    .req_i   (req_q),
    .hit_i   (hit),
    .inst_i  (c_inst[0]),
    .wait_i  (c_wait[0]),
    .rt_i    (c_rt[0]),
    .prio_i  (c_prio[0]),
    .mark_i  (c_mark[0]),
    .inst_o  (u_inst),
    .wait_o  (u_wait),
    .rt_o    (u_rt),
    .prio_o  (u_prio),
    .mark_o  (u_mark),
    .flags_o (flags)
  );

  // summary over the entry that entered the tail cell last cycle
  assign tail_rt   = c_rt[NUM_ENTRIES-1];
  assign tail_wait = c_wait[NUM_ENTRIES-1];
  assign tail_inst = c_inst[NUM_ENTRIES-1];
  assign sum_next  = (tail_wait && (tail_rt < next_q)) ? tail_rt : next_q;
  assign sum_pend  = pend_q ||
                     (tail_wait && tail_inst && (tail_rt != '0) && (tail_rt != ToInf));

  assign status_init = ((req_i.opcode == OP_RESUME) &&
                        (32'(req_i.entry_index) >= 32'(NUM_ENTRIES))) ?
                       ST_NOT_INSTALLED : ST_OK;

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    preempt_d = preempt_q;
    woken_d   = woken_q;
    status_d  = status_q;
    next_d    = next_q;
    pend_d    = pend_q;
    rsp_d     = rsp_q;
    done_d    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d   = S_RUN;
          step_d    = '0;
          preempt_d = 1'b0;
          woken_d   = '0;
          status_d  = status_init;
          next_d    = ToInf;
          pend_d    = 1'b0;
        end
      end
      S_RUN: begin
        step_d    = step_q + 1'b1;
        preempt_d = preempt_q | flags.preempt;
        if (flags.woke) begin
          woken_d = woken_q | (MaskW'(1) << step_q);
        end
        if (flags.status != ST_OK) begin
          status_d = flags.status;
        end
        if (step_q != '0) begin
          next_d = sum_next;
          pend_d = sum_pend;
        end
        if (last_step) begin
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        state_d              = S_IDLE;
        rsp_d.status         = status_q;
        rsp_d.preempt        = preempt_q;
        rsp_d.woken_mask     = woken_q;
        rsp_d.next_wake      = TimeW'(sum_next);
        rsp_d.pending_finite = sum_pend;
        done_d               = 1'b1;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      step_q    <= '0;
      preempt_q <= 1'b0;
      woken_q   <= '0;
      status_q  <= ST_OK;
      next_q    <= '0;
      pend_q    <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      preempt_q <= preempt_d;
      woken_q   <= woken_d;
      status_q  <= status_d;
      next_q    <= next_d;
      pend_q    <= pend_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_ok) begin
      req_q <= req_i;
    end
    rsp_q <= rsp_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
`default_nettype wire

// ----- hw/rtl/tto_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tto_checker
// Port-level checks of the task timeout table, bound to the top level.
// ----------------------------------------------------------------------------
module tto_checker (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                start,
  input wire                busy,
  input tto_pkg::tto_req_t  req_i,
  input wire                done_o,
  input tto_pkg::tto_rsp_t  rsp_o
);
  import tto_pkg::*;

  logic req_seen;
  assign req_seen = (req_i.opcode == OP_QUERY) || (req_i.opcode != OP_QUERY);

  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_seen) |=> busy)
    else $error("transfer taken without going busy");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_busy_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("command finished without a result");

  a_done_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_fail_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.status != ST_OK)) |-> (!rsp_o.preempt && (rsp_o.woken_mask == '0)))
    else $error("failed resume reports a wake");

endmodule

bind task_timeout_table tto_checker u_tto_checker (.*);
`default_nettype wire

// ----- dv/task_timeout_table_test.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// task_timeout_table_test
// Self-checking bench for the task timeout table.
// ----------------------------------------------------------------------------
// A directed sequence covers the corner cases: zero and infinite timeouts,
// saturation on a full-range tick, waiting entries that are not installed,
// refused resumes and preemption by priority or by the idle task. After that
// comes a long random mix of writes, ticks, resumes and queries, the
// timeouts mostly short so entries keep waking. Each transfer is applied
// to a local copy of the table. The predicted result is held in order
// and compared with every done_o pulse.
// ----------------------------------------------------------------------------

import tto_pkg::*;

class wake_tracker;

  localparam int unsigned Entries = 16;

  logic             inst_q  [Entries];
  logic             wait_q  [Entries];
  logic [TimeW-1:0] left_q  [Entries];
  logic [PrioW-1:0] prio_q  [Entries];
  logic             mark_q  [Entries];

  tto_rsp_t due_results[$];
  int       errors;
  int       op_count[4];
  int       woken_count;
  int       preempt_count;
  int       refused_count;

  function new();
    for (int i = 0; i < Entries; i++) begin
      inst_q[i] = 1'b0;
      wait_q[i] = 1'b0;
      left_q[i] = '0;
      prio_q[i] = '0;
      mark_q[i] = 1'b0;
    end
    errors        = 0;
    woken_count   = 0;
    preempt_count = 0;
    refused_count = 0;
    for (int k = 0; k < 4; k++) op_count[k] = 0;
  endfunction

  function logic [TimeW-1:0] minus_floor(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
    return (a < b) ? '0 : a - b;
  endfunction

  function logic wake_entry(int i, logic [PrioW-1:0] run_prio, logic idle);
    wait_q[i] = 1'b0;
    mark_q[i] = 1'b1;
    return (prio_q[i] < run_prio) || idle;
  endfunction

  function void take_command(tto_req_t c);
    tto_rsp_t         r;
    logic [TimeW-1:0] nearest;
    int               idx;
    r         = '0;
    r.status  = ST_OK;
    nearest   = '1;
    idx       = int'(c.entry_index);
    case (c.opcode)
      OP_TICK: begin
        for (int i = 0; i < Entries; i++) begin
          if (wait_q[i] && left_q[i] != '1) begin
            left_q[i] = minus_floor(left_q[i], c.elapsed_ticks);
            if (left_q[i] == '0) begin
              if (wake_entry(i, c.running_priority, c.running_idle)) r.preempt = 1'b1;
              r.woken_mask[i] = 1'b1;
            end
          end
          if (inst_q[i] && !wait_q[i] && left_q[i] != '1)
            left_q[i] = minus_floor(left_q[i], c.elapsed_ticks);
        end
      end
      OP_WRITE: begin
        inst_q[idx] = c.new_installed;
        wait_q[idx] = c.new_waiting;
        left_q[idx] = c.new_timeout;
        prio_q[idx] = c.new_priority;
        mark_q[idx] = 1'b0;
      end
      OP_RESUME: begin
        if (!inst_q[idx]) begin
          r.status = ST_NOT_INSTALLED;
        end else if (!wait_q[idx]) begin
          r.status = ST_NOT_WAITING;
        end else begin
          r.preempt         = wake_entry(idx, c.running_priority, c.running_idle);
          r.woken_mask[idx] = 1'b1;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < Entries; i++) begin
      if (wait_q[i]) begin
        if (left_q[i] < nearest) nearest = left_q[i];
        if (inst_q[i] && left_q[i] != '0 && left_q[i] != '1) r.pending_finite = 1'b1;
      end
    end
    r.next_wake = nearest;
    due_results.push_back(r);
    op_count[int'(c.opcode)]++;
    woken_count += $countones(r.woken_mask);
    if (r.preempt) preempt_count++;
    if (r.status != ST_OK) refused_count++;
  endfunction

  function void check_result(tto_rsp_t got);
    tto_rsp_t exp;
    if (due_results.size() == 0) begin
      errors++;
      $display("%0t: result with nothing outstanding: status %0d preempt %0b woken %h",
               $time, got.status, got.preempt, got.woken_mask);
      $display("%0t:            next %h pend %0b",
               $time, got.next_wake, got.pending_finite);
      return;
    end
    exp = due_results.pop_front();
    if (got !== exp) begin
      errors++;
      $display("%0t: mismatch expected status %0d preempt %0b woken %h next %h pend %0b",
               $time, exp.status, exp.preempt, exp.woken_mask, exp.next_wake,
               exp.pending_finite);
      $display("%0t:            actual status %0d preempt %0b woken %h next %h pend %0b",
               $time, got.status, got.preempt, got.woken_mask, got.next_wake,
               got.pending_finite);
    end
  endfunction

endclass

module task_timeout_table_test;

  localparam int RandomItems = 1250;
  localparam int CalmTail    = 200;
  localparam int CycleLimit  = 400000;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     start;
  logic     busy;
  tto_req_t req;
  logic     done;
  tto_rsp_t rsp;

  wake_tracker tracker;
  int          cycles = 0;

  task_timeout_table uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req),
    .done_o (done),
    .rsp_o  (rsp)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done) tracker.check_result(rsp);
  end

  function automatic tto_req_t noise_cmd();
    logic [95:0]                 raw;
    logic [$bits(tto_req_t)-1:0] bits;
    raw  = {$urandom, $urandom, $urandom};
    bits = raw[$bits(tto_req_t)-1:0];
    return bits;
  endfunction

  function automatic tto_req_t write_cmd(int idx, logic inst, logic wt,
                                         logic [TimeW-1:0] tmo, logic [PrioW-1:0] pr);
    tto_req_t c;
    c               = noise_cmd();
    c.opcode        = OP_WRITE;
    c.entry_index   = idx[IndexW-1:0];
    c.new_installed = inst;
    c.new_waiting   = wt;
    c.new_timeout   = tmo;
    c.new_priority  = pr;
    return c;
  endfunction

  function automatic tto_req_t tick_cmd(logic [TimeW-1:0] el, logic [PrioW-1:0] rp,
                                        logic idle);
    tto_req_t c;
    c                  = noise_cmd();
    c.opcode           = OP_TICK;
    c.elapsed_ticks    = el;
    c.running_priority = rp;
    c.running_idle     = idle;
    return c;
  endfunction

  function automatic tto_req_t resume_cmd(int idx, logic [PrioW-1:0] rp, logic idle);
    tto_req_t c;
    c                  = noise_cmd();
    c.opcode           = OP_RESUME;
    c.entry_index      = idx[IndexW-1:0];
    c.running_priority = rp;
    c.running_idle     = idle;
    return c;
  endfunction

  function automatic tto_req_t query_cmd();
    tto_req_t c;
    c        = noise_cmd();
    c.opcode = OP_QUERY;
    return c;
  endfunction

  function automatic logic [TimeW-1:0] pick_timeout();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return '1 - 1;
      3:       return $urandom;
      default: return $urandom_range(1, 30);
    endcase
  endfunction

  function automatic logic [TimeW-1:0] pick_elapsed();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      default: return $urandom_range(0, 6);
    endcase
  endfunction

  function automatic tto_req_t random_cmd();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 30)
      return write_cmd($urandom_range(0, 15), $urandom_range(0, 9) < 8,
                       $urandom_range(0, 9) < 7, pick_timeout(),
                       PrioW'($urandom_range(0, 255)));
    if (sel < 62)
      return tick_cmd(pick_elapsed(), PrioW'($urandom_range(0, 255)),
                      $urandom_range(0, 4) == 0);
    if (sel < 82)
      return resume_cmd($urandom_range(0, 15), PrioW'($urandom_range(0, 255)),
                        $urandom_range(0, 4) == 0);
    return query_cmd();
  endfunction

  // one transfer; optional idle burst after it, either at once or once the
  // block has gone idle
  task automatic issue(input tto_req_t cmd, input bit may_idle);
    int sel;
    req   <= cmd;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    tracker.take_command(cmd);
    if (may_idle) begin
      sel = $urandom_range(0, 99);
      if (sel >= 60) begin
        start <= 1'b0;
        if (sel >= 80) begin
          do @(posedge clk_i); while (busy);
        end
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    tracker = new();
    rst_ni  = 1'b0;
    start   = 1'b0;
    req     = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(query_cmd(), 1'b1);
    issue(write_cmd(0, 1'b1, 1'b1, 32'd5, 8'd3), 1'b1);
    issue(write_cmd(15, 1'b1, 1'b1, '1, 8'd255), 1'b1);
    issue(write_cmd(1, 1'b0, 1'b1, 32'd2, 8'd0), 1'b1);
    issue(write_cmd(2, 1'b1, 1'b0, 32'd10, 8'd1), 1'b1);
    issue(query_cmd(), 1'b1);
    issue(resume_cmd(3, 8'd0, 1'b0), 1'b1);
    issue(resume_cmd(2, 8'd0, 1'b0), 1'b1);
    issue(tick_cmd(32'd1, 8'd5, 1'b0), 1'b1);
    issue(tick_cmd(32'd4, 8'd5, 1'b0), 1'b1);
    issue(tick_cmd(32'd0, 8'd0, 1'b0), 1'b1);
    issue(write_cmd(4, 1'b1, 1'b1, 32'd0, 8'd9), 1'b1);
    issue(tick_cmd(32'd0, 8'd9, 1'b0), 1'b1);
    issue(write_cmd(5, 1'b1, 1'b1, 32'd100, 8'd200), 1'b1);
    issue(resume_cmd(5, 8'd10, 1'b1), 1'b1);
    issue(write_cmd(6, 1'b1, 1'b1, '1 - 1, 8'd0), 1'b1);
    issue(write_cmd(7, 1'b1, 1'b1, 32'hFFFF_0000, 8'd255), 1'b1);
    issue(tick_cmd('1, 8'd0, 1'b0), 1'b1);
    issue(resume_cmd(15, 8'd255, 1'b0), 1'b1);
    issue(write_cmd(8, 1'b1, 1'b1, 32'd1, 8'd254), 1'b1);
    issue(tick_cmd(32'd1, 8'd255, 1'b0), 1'b1);
    issue(write_cmd(1, 1'b0, 1'b0, 32'd0, 8'd0), 1'b1);
    issue(query_cmd(), 1'b1);

    for (int n = 0; n < RandomItems; n++)
      issue(random_cmd(), n < RandomItems - CalmTail);

    start <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("ran %0d ticks, %0d writes, %0d resumes, %0d queries",
             tracker.op_count[OP_TICK], tracker.op_count[OP_WRITE],
             tracker.op_count[OP_RESUME], tracker.op_count[OP_QUERY]);
    $display("entries woken %0d, preempts %0d, refused resumes %0d, mismatches %0d",
             tracker.woken_count, tracker.preempt_count, tracker.refused_count,
             tracker.errors);
    if (tracker.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
